// File: rtl/mrlp_pkg.sv
// shared types and constants of the modem response line parser
`timescale 1ns / 1ps

package mrlp_pkg;

   // default geometry of the payload store
   localparam int MAX_LINES_DEF      = 8;
   localparam int MAX_LINE_CHARS_DEF = 64;

   // fixed transaction widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;
   localparam int CHAR_W      = 7;

   // action selector carried in req_tuser
   localparam logic ACTION_PARSE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_K     = 8'h4B;
   localparam logic [7:0] CHAR_R     = 8'h52;

   typedef enum logic [1:0] {
      STATUS_NOT_READY = 2'd0,
      STATUS_READY     = 2'd1,
      STATUS_ERROR     = 2'd2
   } status_type;

   // per-transaction result handed from the parser to the output pipeline
   typedef struct packed {
      status_type status;
      logic       result_ok;
      logic [3:0] lines_stored;
      logic       read_hit;
   } result_type;

endpackage

// File: rtl/mrlp_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mrlp_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mrlp_parser.sv
// response recognizer, line and column counters and line length table
`timescale 1ns / 1ps

module mrlp_parser #(
   parameter int MAX_LINES      = mrlp_pkg::MAX_LINES_DEF,
   parameter int MAX_LINE_CHARS = mrlp_pkg::MAX_LINE_CHARS_DEF,
   localparam int ADDR_W        = $clog2(MAX_LINES * MAX_LINE_CHARS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         action,
   input  logic [7:0]                   rx_byte,
   input  logic [2:0]                   read_line,
   input  logic [5:0]                   read_column,
   output mrlp_pkg::result_type         result,
   output logic                         wr_en,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic [mrlp_pkg::CHAR_W-1:0]  wr_data,
   output logic [ADDR_W-1:0]            rd_addr
);

   localparam int LCNT_W = $clog2(MAX_LINES + 1);
   localparam int COL_W  = $clog2(MAX_LINE_CHARS + 1);
   localparam int IDX_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

   typedef enum logic [16:0] {
      S_START      = 17'b00000000000000001,
      S_LF1        = 17'b00000000000000010,
      S_FIRST      = 17'b00000000000000100,
      S_OK_K       = 17'b00000000000001000,
      S_ERR_R1     = 17'b00000000000010000,
      S_ERR_R2     = 17'b00000000000100000,
      S_ERR_O      = 17'b00000000001000000,
      S_ERR_R3     = 17'b00000000010000000,
      S_END_CR     = 17'b00000000100000000,
      S_END_LF     = 17'b00000001000000000,
      S_PLUS_FIRST = 17'b00000010000000000,
      S_PLUS_TEXT  = 17'b00000100000000000,
      S_LINE_LF    = 17'b00001000000000000,
      S_LINE_NEXT  = 17'b00010000000000000,
      S_BLANK_LF   = 17'b00100000000000000,
      S_FINAL      = 17'b01000000000000000,
      S_PLAIN_TEXT = 17'b10000000000000000
   } parse_state_type;

   parse_state_type    state_ff, state_in;
   logic               plain_ff, plain_in;
   logic               ok_ff, ok_in;
   logic [LCNT_W-1:0]  lc_ff, lc_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COL_W-1:0]   len_ff [MAX_LINES];

   mrlp_pkg::status_type status;
   logic store_req, end_req, store_ok, end_ok, is_print, parse_go;
   logic [LCNT_W-1:0]  lc_base;
   logic [COL_W-1:0]   col_base;
   logic               in_range, hit;
   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   wr_idx;

   assign is_print = (rx_byte >= mrlp_pkg::CHAR_SPACE) && (rx_byte <= mrlp_pkg::CHAR_TILDE);
   assign parse_go = accept && (action == mrlp_pkg::ACTION_PARSE);

   always_comb begin
      state_in  = state_ff;
      plain_in  = plain_ff;
      ok_in     = ok_ff;
      lc_base   = lc_ff;
      col_base  = col_ff;
      status    = mrlp_pkg::STATUS_NOT_READY;
      store_req = 1'b0;
      end_req   = 1'b0;
      unique case (state_ff)
         S_START: begin
            // every byte here clears the store, counters and result bit
            lc_base  = '0;
            col_base = '0;
            ok_in    = 1'b0;
            if (rx_byte == mrlp_pkg::CHAR_CR) state_in = S_LF1;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_LF1: begin
            if (rx_byte == mrlp_pkg::CHAR_LF) state_in = S_FIRST;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_FIRST: begin
            if (rx_byte == mrlp_pkg::CHAR_O) state_in = S_OK_K;
            else if (rx_byte == mrlp_pkg::CHAR_E) state_in = S_ERR_R1;
            else if (rx_byte == mrlp_pkg::CHAR_PLUS) state_in = S_PLUS_FIRST;
            else if (is_print) begin
               store_req = 1'b1;
               plain_in  = 1'b1;
               state_in  = S_PLAIN_TEXT;
            end else status = mrlp_pkg::STATUS_ERROR;
         end
         S_OK_K: begin
            if (rx_byte == mrlp_pkg::CHAR_K) begin
               ok_in    = 1'b1;
               state_in = S_END_CR;
            end else status = mrlp_pkg::STATUS_ERROR;
         end
         S_ERR_R1: begin
            if (rx_byte == mrlp_pkg::CHAR_R) state_in = S_ERR_R2;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_ERR_R2: begin
            if (rx_byte == mrlp_pkg::CHAR_R) state_in = S_ERR_O;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_ERR_O: begin
            if (rx_byte == mrlp_pkg::CHAR_O) state_in = S_ERR_R3;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_ERR_R3: begin
            if (rx_byte == mrlp_pkg::CHAR_R) begin
               ok_in    = 1'b0;
               state_in = S_END_CR;
            end else status = mrlp_pkg::STATUS_ERROR;
         end
         S_END_CR: begin
            if (rx_byte == mrlp_pkg::CHAR_CR) state_in = S_END_LF;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_END_LF: begin
            if (rx_byte == mrlp_pkg::CHAR_LF) begin
               state_in = S_START;
               plain_in = 1'b0;
               status   = mrlp_pkg::STATUS_READY;
            end else status = mrlp_pkg::STATUS_ERROR;
         end
         S_PLUS_FIRST: begin
            if (is_print) begin
               store_req = 1'b1;
               state_in  = S_PLUS_TEXT;
            end else status = mrlp_pkg::STATUS_ERROR;
         end
         S_PLUS_TEXT, S_PLAIN_TEXT: begin
            if (is_print) store_req = 1'b1;
            else if (rx_byte == mrlp_pkg::CHAR_CR) begin
               end_req  = 1'b1;
               state_in = S_LINE_LF;
            end else status = mrlp_pkg::STATUS_ERROR;
         end
         S_LINE_LF: begin
            if (rx_byte == mrlp_pkg::CHAR_LF) state_in = S_LINE_NEXT;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_LINE_NEXT: begin
            if (rx_byte == mrlp_pkg::CHAR_CR) state_in = S_BLANK_LF;
            else if (!plain_ff && rx_byte == mrlp_pkg::CHAR_PLUS) state_in = S_PLUS_FIRST;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_BLANK_LF: begin
            if (rx_byte == mrlp_pkg::CHAR_LF) state_in = S_FINAL;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         S_FINAL: begin
            if (rx_byte == mrlp_pkg::CHAR_O) state_in = S_OK_K;
            else if (rx_byte == mrlp_pkg::CHAR_E) state_in = S_ERR_R1;
            else status = mrlp_pkg::STATUS_ERROR;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // characters beyond the line length or line count are dropped
   assign store_ok = store_req && (32'(col_base) < MAX_LINE_CHARS)
                   && (32'(lc_base) < MAX_LINES);
   assign end_ok   = end_req && (32'(lc_base) < MAX_LINES);

   always_comb begin
      lc_in  = lc_base;
      col_in = col_base;
      if (store_ok) col_in = col_base + COL_W'(1);
      if (end_ok) begin
         lc_in  = lc_base + LCNT_W'(1);
         col_in = '0;
      end
   end

   assign wr_idx  = IDX_W'(lc_ff);
   assign wr_en   = parse_go && store_ok;
   assign wr_addr = ADDR_W'(32'(lc_ff) * MAX_LINE_CHARS + 32'(col_ff));
   assign wr_data = rx_byte[mrlp_pkg::CHAR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         plain_ff <= 1'b0;
         ok_ff    <= 1'b0;
         lc_ff    <= '0;
         col_ff   <= '0;
      end else if (parse_go) begin
         state_ff <= state_in;
         plain_ff <= plain_in;
         ok_ff    <= ok_in;
         lc_ff    <= lc_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (parse_go && end_ok) begin
         len_ff[wr_idx] <= col_base;
      end
   end

   // a position holds data only if written since the last clear: lines below
   // the line count up to their length, the open line up to the column count
   assign rd_idx   = IDX_W'(read_line);
   assign in_range = (32'(read_line) < MAX_LINES) && (32'(read_column) < MAX_LINE_CHARS);
   always_comb begin
      hit = 1'b0;
      if (in_range) begin
         if (32'(read_line) < 32'(lc_ff)) hit = 32'(read_column) < 32'(len_ff[rd_idx]);
         else if (32'(read_line) == 32'(lc_ff)) hit = 32'(read_column) < 32'(col_ff);
      end
   end
   assign rd_addr = ADDR_W'(32'(read_line) * MAX_LINE_CHARS + 32'(read_column));

   always_comb begin
      if (action == mrlp_pkg::ACTION_PARSE) begin
         result.status       = status;
         result.result_ok    = ok_in;
         result.lines_stored = 4'(lc_in);
         result.read_hit     = 1'b0;
      end else begin
         result.status       = mrlp_pkg::STATUS_NOT_READY;
         result.result_ok    = ok_ff;
         result.lines_stored = 4'(lc_ff);
         result.read_hit     = hit;
      end
   end

endmodule

// File: rtl/modem_response_line_parser_core.sv
// top level of the modem response line parser: stream ports, store and output pipeline
`timescale 1ns / 1ps

// Parses modem responses one received byte per transaction and reports a status for
// every byte (not ready, response complete, syntax error) together with the OK/ERROR
// result bit and the count of completed payload lines. A read transaction returns one
// stored payload character, zero for positions not written since the store was last
// cleared (any byte seen in the start state clears it at once, no sweep needed, since
// the line length table and counters mark which positions hold data). One transaction
// is accepted every clock cycle while the receiver keeps up; each result passes through
// stage one, captured beside the registered read of the payload ram, and then through
// the output register before its response handshake.

module modem_response_line_parser_core #(
   parameter int MAX_LINES      = mrlp_pkg::MAX_LINES_DEF,
   parameter int MAX_LINE_CHARS = mrlp_pkg::MAX_LINE_CHARS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request transactions
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rx_byte [7:0], read_line [10:8], read_column [16:11], zero fill above
   input  logic [mrlp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action: 0 parse rx_byte, 1 read one stored character
   input  logic                            req_tuser,
   // response transactions
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], result_ok [2], lines_stored [6:3], read_char [13:7], zero fill above
   output logic [mrlp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int DEPTH  = MAX_LINES * MAX_LINE_CHARS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                          accept;
   mrlp_pkg::result_type          result;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [mrlp_pkg::CHAR_W-1:0]   wr_data;
   logic [ADDR_W-1:0]             rd_addr;
   logic [mrlp_pkg::CHAR_W-1:0]   rd_data;

   // stage one: result captured beside the ram's registered read
   logic                          s1_valid_ff;
   mrlp_pkg::result_type          s1_res_ff;
   logic                          s1_move;
   // output register
   logic                          out_valid_ff;
   logic [mrlp_pkg::RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic [mrlp_pkg::CHAR_W-1:0]   read_char;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   mrlp_parser #(
      .MAX_LINES      (MAX_LINES),
      .MAX_LINE_CHARS (MAX_LINE_CHARS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_tuser),
      .rx_byte     (req_tdata[7:0]),
      .read_line   (req_tdata[10:8]),
      .read_column (req_tdata[16:11]),
      .result      (result),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr)
   );

   // payload character store, one row of MAX_LINE_CHARS per line
   mrlp_ram #(
      .WIDTH (mrlp_pkg::CHAR_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
      end
   end

   // unwritten positions and parse transactions read as zero
   assign read_char   = s1_res_ff.read_hit ? rd_data : '0;
   assign out_data_in = {2'b00, read_char, s1_res_ff.lines_stored,
                         s1_res_ff.result_ok, s1_res_ff.status};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // back pressure only when both pipeline slots are full
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && out_valid_ff))
      else $error("request side stalled with a free pipeline slot");

   // store writes come only from accepted parse transactions
   a_write_on_parse: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (accept && (req_tuser == mrlp_pkg::ACTION_PARSE)))
      else $error("store written outside a parse transaction");

   // a parse status and a read hit never come together
   a_hit_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_res_ff.status != mrlp_pkg::STATUS_NOT_READY)
      |-> !s1_res_ff.read_hit)
      else $error("read hit flagged on a parse result");

   // a waiting response is not overwritten by stage one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("pending response lost");

endmodule
